>>> rtl/core/rcef_pkg.sv
package rcef_pkg;

    localparam int PIX_W          = 8;
    localparam int ROW_W          = 10;
    localparam int OUT_COL_W      = 10;
    localparam int DIM_W          = 11;
    localparam int FIELD_CHANNELS = 3;
    localparam int MAX_HEIGHT     = 1024;
    localparam int MIN_DIM        = 3;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // per-pixel position flags handed from the counters to the datapath
    typedef struct packed {
        logic emit;
        logic last;
    } t_pos_flags;

endpackage

>>> rtl/core/rcef_line_store.sv
module rcef_line_store
    import rcef_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int DW    = 24,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output logic [DW-1:0] o_rd_data_a,
    output logic [DW-1:0] o_rd_data_b,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read before write on a shared address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> rtl/core/rcef_lane.sv
module rcef_lane
    import rcef_pkg::*;
(
    input  logic [PIX_W-1:0] i_centre,
    input  logic [PIX_W-1:0] i_up,
    input  logic [PIX_W-1:0] i_down,
    input  logic [PIX_W-1:0] i_left,
    input  logic [PIX_W-1:0] i_right,
    output logic [PIX_W-1:0] o_min
);

    logic [PIX_W-1:0] m_ud;
    logic [PIX_W-1:0] m_lr;
    logic [PIX_W-1:0] m_cud;

    // small tree: two pairs first, then the center, then the last pair
    always_comb begin
        m_ud  = (i_up < i_down) ? i_up : i_down;
        m_lr  = (i_left < i_right) ? i_left : i_right;
        m_cud = (i_centre < m_ud) ? i_centre : m_ud;
        o_min = (m_cud < m_lr) ? m_cud : m_lr;
    end

endmodule

>>> rtl/core/rcef_pos_ctrl.sv
module rcef_pos_ctrl
    import rcef_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    output logic [ROW_W-1:0] o_row,
    output logic [AW-1:0]    o_col,
    output t_pos_flags       o_flags
);

    localparam int CW = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;
    localparam int HW = DIM_W;

    localparam logic [CW-1:0] MAX_W_C = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] MIN_W_C = CW'(MIN_DIM);
    localparam logic [HW-1:0] MAX_H_C = HW'(MAX_HEIGHT);
    localparam logic [HW-1:0] MIN_H_C = HW'(MIN_DIM);

    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    logic [CW-1:0] width_x;
    logic [CW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          wrap_pre;
    logic [HW-1:0] row_pre;
    logic [ROW_W-1:0] row_cur;
    logic [AW-1:0] col_cur;
    logic [CW-1:0] col_x;
    logic [CW-1:0] col_nx;
    logic [HW-1:0] row_nx;

    always_comb begin
        width_x = CW'(i_width);
        if (width_x < MIN_W_C) begin
            w_eff = MIN_W_C;
        end else if (width_x > MAX_W_C) begin
            w_eff = MAX_W_C;
        end else begin
            w_eff = width_x;
        end
        if (i_height < MIN_H_C) begin
            h_eff = MIN_H_C;
        end else if (i_height > MAX_H_C) begin
            h_eff = MAX_H_C;
        end else begin
            h_eff = i_height;
        end

        // counters left beyond a shrunk limit wrap before use
        wrap_pre = CW'(r_col) >= w_eff;
        row_pre  = HW'(r_row) + HW'(wrap_pre);
        col_cur  = wrap_pre ? '0 : r_col;
        row_cur  = (row_pre >= h_eff) ? '0 : row_pre[ROW_W-1:0];
        col_x    = CW'(col_cur);

        o_flags.emit = (row_cur >= ROW_W'(2)) && (col_cur != '0)
                       && (col_x <= w_eff - CW'(2));
        o_flags.last = (HW'(row_cur) == h_eff - HW'(1)) && (col_x == w_eff - CW'(2));

        col_nx = col_x + CW'(1);
        row_nx = HW'(row_cur) + HW'(1);
        if (col_nx >= w_eff) begin
            n_col = '0;
            n_row = (row_nx >= h_eff) ? '0 : row_nx[ROW_W-1:0];
        end else begin
            n_col = col_nx[AW-1:0];
            n_row = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_step) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_row = row_cur;
    assign o_col = col_cur;

endmodule

>>> rtl/core/rgb_cross_erosion_filter_unit.sv
// channel    | direction | handshake              | payload
// pixel in   | input     | i_valid / o_ready      | i_in_red, i_in_green, i_in_blue
// result out | output    | o_valid / i_ready      | o_out_red/green/blue, o_out_row,
//            |           |                        | o_out_col, o_frame_last
// config     | apb       | psel, penable, pready  | paddr, pwdata, prdata
//
// one pixel per clock while the output is not stalled; a result passes from its accepted
// pixel through the line-store read, then the min lanes into the output register.
// each line store has two registered read ports and one write port, written when
// the pixel leaves its stage; a same-edge hit on the left neighbor is forwarded.
// synchronous active-low reset clears counters and valids, width 640, height 480.
// line stores are not cleared; a stalled output holds an emitting pixel in its stage, drops o_ready.
module rgb_cross_erosion_filter_unit
    import rcef_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int CHANNEL_COUNT = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIX_W-1:0]      i_in_red,
    input  logic [PIX_W-1:0]      i_in_green,
    input  logic [PIX_W-1:0]      i_in_blue,

    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIX_W-1:0]      o_out_red,
    output logic [PIX_W-1:0]      o_out_green,
    output logic [PIX_W-1:0]      o_out_blue,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [OUT_COL_W-1:0]  o_out_col,
    output logic                  o_frame_last
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int FILT = (CHANNEL_COUNT < FIELD_CHANNELS) ? CHANNEL_COUNT : FIELD_CHANNELS;
    localparam int DW   = FILT * PIX_W;

    // configuration registers
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    // position tracking
    logic             accept;
    logic [ROW_W-1:0] pos_row;
    logic [AW-1:0]    pos_col;
    t_pos_flags       pos_flags;

    assign accept = i_valid & o_ready;

    rcef_pos_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_width  (r_width),
        .i_height (r_height),
        .o_row    (pos_row),
        .o_col    (pos_col),
        .o_flags  (pos_flags)
    );

    // incoming pixel packed by lane
    logic [PIX_W-1:0] in_ch [FIELD_CHANNELS];
    logic [DW-1:0]    pix;

    assign in_ch[0] = i_in_red;
    assign in_ch[1] = i_in_green;
    assign in_ch[2] = i_in_blue;

    for (genvar g = 0; g < FILT; g++) begin : g_pack
        assign pix[g*PIX_W +: PIX_W] = in_ch[g];
    end

    // pixel stage, waiting on line-store read data
    logic             r_s1_valid;
    t_pos_flags       r_s1_flags;
    logic [DW-1:0]    r_s1_pix;
    logic [AW-1:0]    r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_fwd_sel;
    logic [DW-1:0]    r_fwd_data;
    logic             s1_adv;

    logic [DW-1:0] ra_c;
    logic [DW-1:0] ra_n;
    logic [DW-1:0] ta_c;
    logic [DW-1:0] ta_l;
    logic [DW-1:0] left_data;

    logic r_out_valid;

    assign s1_adv  = r_s1_valid & (~r_s1_flags.emit | ~r_out_valid | i_ready);
    assign o_ready = ~r_s1_valid | s1_adv;

    rcef_line_store #(
        .DEPTH (MAX_WIDTH),
        .DW    (DW),
        .AW    (AW)
    ) u_row_above (
        .i_clk       (i_clk),
        .i_rd_en     (accept),
        .i_rd_addr_a (pos_col),
        .i_rd_addr_b (pos_col + AW'(1)),
        .o_rd_data_a (ra_c),
        .o_rd_data_b (ra_n),
        .i_wr_en     (s1_adv),
        .i_wr_addr   (r_s1_col),
        .i_wr_data   (r_s1_pix)
    );

    rcef_line_store #(
        .DEPTH (MAX_WIDTH),
        .DW    (DW),
        .AW    (AW)
    ) u_row_two_above (
        .i_clk       (i_clk),
        .i_rd_en     (accept),
        .i_rd_addr_a (pos_col),
        .i_rd_addr_b (pos_col - AW'(1)),
        .o_rd_data_a (ta_c),
        .o_rd_data_b (ta_l),
        .i_wr_en     (s1_adv),
        .i_wr_addr   (r_s1_col),
        .i_wr_data   (ra_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // the previous pixel writes its column at the edge this one reads it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flags <= pos_flags;
            r_s1_pix   <= pix;
            r_s1_col   <= pos_col;
            r_s1_row   <= pos_row - ROW_W'(1);
            r_fwd_sel  <= r_s1_valid && (pos_col - AW'(1) == r_s1_col);
            r_fwd_data <= ra_c;
        end
    end

    assign left_data = r_fwd_sel ? r_fwd_data : ta_l;

    // min lanes
    logic [PIX_W-1:0] lane_min [FIELD_CHANNELS];

    for (genvar g = 0; g < FIELD_CHANNELS; g++) begin : g_lane
        if (g < FILT) begin : g_on
            rcef_lane u_lane (
                .i_centre (ra_c[g*PIX_W +: PIX_W]),
                .i_up     (ta_c[g*PIX_W +: PIX_W]),
                .i_down   (r_s1_pix[g*PIX_W +: PIX_W]),
                .i_left   (left_data[g*PIX_W +: PIX_W]),
                .i_right  (ra_n[g*PIX_W +: PIX_W]),
                .o_min    (lane_min[g])
            );
        end else begin : g_off
            assign lane_min[g] = '0;
        end
    end

    // output register merges lanes with position
    logic [PIX_W-1:0]     r_out_ch [FIELD_CHANNELS];
    logic [ROW_W-1:0]     r_out_row;
    logic [OUT_COL_W-1:0] r_out_col;
    logic                 r_out_last;
    logic                 load_out;

    assign load_out = s1_adv & r_s1_flags.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_ch   <= lane_min;
            r_out_row  <= r_s1_row;
            r_out_col  <= OUT_COL_W'(r_s1_col);
            r_out_last <= r_s1_flags.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_red    = r_out_ch[0];
    assign o_out_green  = r_out_ch[1];
    assign o_out_blue   = r_out_ch[2];
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_frame_last = r_out_last;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import rcef_pkg::*;
();

    localparam int LINE_MAX   = 1024;
    localparam int CYCLE_CAP  = 100_000;
    localparam int DRAIN_WAIT = 8;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } t_eroded;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_in_red = '0;
    logic [PIX_W-1:0]      i_in_green = '0;
    logic [PIX_W-1:0]      i_in_blue = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PIX_W-1:0]      o_out_red;
    logic [PIX_W-1:0]      o_out_green;
    logic [PIX_W-1:0]      o_out_blue;
    logic [ROW_W-1:0]      o_out_row;
    logic [OUT_COL_W-1:0]  o_out_col;
    logic                  o_frame_last;

    rgb_cross_erosion_filter_unit #(
        .MAX_WIDTH     (LINE_MAX),
        .CHANNEL_COUNT (FIELD_CHANNELS)
    ) dut (.*);

    always #10 i_clk = ~i_clk;

    // pixel stream and eroded pixels still owed by the block
    t_rgb    pixel_q[$];
    t_eroded eroded_q[$];

    int unsigned pixels_sent = 0;
    int unsigned pixels_taken = 0;
    int unsigned results_seen = 0;
    int unsigned settings_used = 0;
    int unsigned errors = 0;
    int unsigned cycle_cnt = 0;
    bit          idle_on = 1'b1;
    bit          pix_taken = 1'b0;
    int          send_hold = 0;
    int          recv_hold = 0;

    // filter model state
    t_rgb             line_above [LINE_MAX];
    t_rgb             line_two_above [LINE_MAX];
    bit               above_ok [LINE_MAX];
    bit               two_ok [LINE_MAX];
    int               row_cnt = 0;
    int               col_cnt = 0;
    logic [DIM_W-1:0] cfg_width = WIDTH_RESET;
    logic [DIM_W-1:0] cfg_height = HEIGHT_RESET;

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] chan_min(input logic [PIX_W-1:0] a, b, c, d, e);
        logic [PIX_W-1:0] m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        if (d < m) m = d;
        if (e < m) m = e;
        return m;
    endfunction

    function automatic void predict_erosion(input t_rgb px);
        int      w;
        int      h;
        int      r;
        int      c;
        t_eroded res;
        w = clamp_dim(cfg_width, LINE_MAX);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        // counters left past a shrunken limit wrap before this pixel
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        r = row_cnt;
        c = col_cnt;
        if (r >= 2 && c >= 1 && c <= w - 2) begin
            // line_two_above[c-1] already holds the left neighbour of the centre
            res.red   = chan_min(line_above[c].red, line_two_above[c].red, px.red,
                                 line_two_above[c-1].red, line_above[c+1].red);
            res.green = chan_min(line_above[c].green, line_two_above[c].green, px.green,
                                 line_two_above[c-1].green, line_above[c+1].green);
            res.blue  = chan_min(line_above[c].blue, line_two_above[c].blue, px.blue,
                                 line_two_above[c-1].blue, line_above[c+1].blue);
            res.row   = ROW_W'(r - 1);
            res.col   = OUT_COL_W'(c);
            res.last  = (r == h - 1 && c == w - 2);
            eroded_q.push_back(res);
        end
        two_ok[c] = above_ok[c];
        above_ok[c] = 1'b1;
        line_two_above[c] = line_above[c];
        line_above[c] = px;
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
        end
    endfunction

    // a new width must never make the block read a line-store entry never written
    function automatic bit width_change_ok(input logic [DIM_W-1:0] wreg, hreg);
        int w;
        int h;
        int r;
        int c;
        w = clamp_dim(wreg, LINE_MAX);
        h = clamp_dim(hreg, MAX_HEIGHT);
        r = row_cnt;
        c = col_cnt;
        if (w == clamp_dim(cfg_width, LINE_MAX)) return 1'b1;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;
        if (r == 0) return 1'b1;
        for (int k = 0; k < w; k++)
            if (!above_ok[k] || !two_ok[k]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int pixels_to_frame_end();
        int w;
        int h;
        int r;
        int c;
        w = clamp_dim(cfg_width, LINE_MAX);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        r = row_cnt;
        c = col_cnt;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;
        return w * h - (r * w + c);
    endfunction

    function automatic logic [APB_ADDR_W-1:0] reg_addr(input t_reg_idx idx);
        return APB_ADDR_W'({idx, 2'b00});
    endfunction

    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // model update on register writes and accepted pixels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_taken <= 1'b0;
        end else begin
            pix_taken <= i_valid && o_ready;
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_ADDR_W-1:2]))
                    REG_WIDTH:  cfg_width = pwdata[DIM_W-1:0];
                    REG_HEIGHT: cfg_height = pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                pixels_taken++;
                predict_erosion('{i_in_red, i_in_green, i_in_blue});
            end
        end
    end

    always @(posedge i_clk) begin
        t_eroded want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (eroded_q.size() == 0) begin
                $display("%0t: unexpected result at row %0d col %0d", $time, o_out_row,
                         o_out_col);
                errors++;
            end else begin
                want = eroded_q.pop_front();
                check_field("red", want.red, o_out_red);
                check_field("green", want.green, o_out_green);
                check_field("blue", want.blue, o_out_blue);
                check_field("row", want.row, o_out_row);
                check_field("col", want.col, o_out_col);
                check_field("frame_last", want.last, o_frame_last);
            end
        end
    end

    // pixel driver
    always @(negedge i_clk) begin
        t_rgb px;
        if (i_rst_n && (!i_valid || pix_taken)) begin
            if (send_hold > 0) begin
                send_hold <= send_hold - 1;
                i_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                send_hold <= $urandom_range(0, 10);
                i_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                px = pixel_q.pop_front();
                i_valid <= 1'b1;
                i_in_red <= px.red;
                i_in_green <= px.green;
                i_in_blue <= px.blue;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            recv_hold <= $urandom_range(0, 10);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     eroded_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_read_check(input t_reg_idx idx, input logic [DIM_W-1:0] want);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= reg_addr(idx);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[DIM_W-1:0] !== want) begin
            $display("%0t: %s read back 0x%0h, expected 0x%0h", $time, idx.name(),
                     prdata[DIM_W-1:0], want);
            errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [DIM_W-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= reg_addr(idx);
        pwdata <= APB_DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_read_check(idx, val);
    endtask

    task automatic set_size(input logic [DIM_W-1:0] w, h);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        settings_used++;
    endtask

    // block idle: every pixel taken, every result back, pipeline flushed
    task automatic settle();
        while (pixels_taken != pixels_sent || eroded_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic queue_pattern(input int first, input int count);
        t_rgb px;
        for (int k = first; k < first + count; k++) begin
            px.red = PIX_W'(k * 53);
            px.green = PIX_W'(8'hAA ^ PIX_W'(k * 29));
            px.blue = PIX_W'(255 - k * 13);
            if (k == 0) px = '0;
            if (k == 21) px = '1;
            pixel_q.push_back(px);
            pixels_sent++;
        end
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++) begin
            pixel_q.push_back('{rand_chan(), rand_chan(), rand_chan()});
            pixels_sent++;
        end
    endtask

    initial begin
        int               rand_sent;
        int               count;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        rand_sent = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        reg_read_check(REG_WIDTH, WIDTH_RESET);
        reg_read_check(REG_HEIGHT, HEIGHT_RESET);

        // one 4x3 frame and part of the next, then a width shrink that wraps row 1 early
        set_size(11'd4, 11'd3);
        queue_pattern(0, 19);
        settle();
        set_size(11'd2, 11'd3);
        queue_pattern(19, 3);
        settle();

        // sizes given out of range: a start of the widest row, then a tall narrow strip
        set_size(11'd2047, 11'd0);
        queue_random(40);
        settle();
        set_size(11'd0, 11'd2047);
        queue_random(40);
        settle();

        while (rand_sent < 360) begin
            idle_on = (rand_sent < 290) ? ($urandom_range(0, 3) != 0) : 1'b0;
            case ($urandom_range(0, 15))
                0: w = DIM_W'($urandom_range(0, 2));
                1: w = DIM_W'($urandom_range(1025, 2047));
                default: w = DIM_W'($urandom_range(3, 10));
            endcase
            case ($urandom_range(0, 15))
                0: h = DIM_W'($urandom_range(0, 2));
                1: h = DIM_W'($urandom_range(1025, 2047));
                default: h = DIM_W'($urandom_range(3, 6));
            endcase
            if (!width_change_ok(w, h)) w = cfg_width;
            set_size(w, h);
            // mostly whole frames; big sizes and some phases stop mid-frame
            if (pixels_to_frame_end() > 200 || $urandom_range(0, 3) == 0)
                count = $urandom_range(1, 40);
            else
                count = pixels_to_frame_end();
            queue_random(count);
            rand_sent += count;
            settle();
        end

        $display("%0d pixels streamed, %0d eroded pixels compared, %0d size settings",
                 pixels_taken, results_seen, settings_used);
        $display("small frames, clamped sizes up to 1024, partial frames, mid-frame resizes");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
